FILE: hw/rtl/kmtf_pkg.sv
package kmtf_pkg;

  typedef enum logic [1:0] {
    ACT_APPLY = 2'd0,
    ACT_FIND  = 2'd1,
    ACT_MARK  = 2'd2,
    ACT_ERASE = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    KIND_RESET  = 3'd0,
    KIND_REMOVE = 3'd1,
    KIND_ADD    = 3'd2,
    KIND_HIST   = 3'd3,
    KIND_LOCAL  = 3'd4,
    KIND_UPDATE = 3'd5,
    KIND_SPARE6 = 3'd6,
    KIND_SPARE7 = 3'd7
  } kind_e;

  localparam int unsigned InDataW  = 168;
  localparam int unsigned OutDataW = 136;

  typedef struct packed {
    logic start;
    logic scan;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_busy;
  } status_t;

endpackage

FILE: hw/rtl/kmtf_ctrl.sv
module kmtf_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  kmtf_pkg::status_t status_i,
  output kmtf_pkg::cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_COMMIT
  } state_e;

  state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      unique case (state_q)
        ST_IDLE:   if (in_valid_i) state_q <= ST_SCAN;
        ST_SCAN:   if (status_i.scan_last) state_q <= ST_LAST;
        ST_LAST:   state_q <= ST_COMMIT;
        ST_COMMIT: if (!status_i.out_busy) state_q <= ST_IDLE;
        default:   state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o    = (state_q == ST_IDLE);
  assign cmd_o.start   = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.scan    = (state_q == ST_SCAN);
  assign cmd_o.commit  = (state_q == ST_COMMIT) && !status_i.out_busy;

endmodule

FILE: hw/rtl/kmtf_dp.sv
module kmtf_dp #(
  parameter int unsigned Depth = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  kmtf_pkg::cmd_t          cmd_i,
  output kmtf_pkg::status_t       status_o,
  input  logic [1:0]              action_i,
  input  logic [2:0]              change_kind_i,
  input  logic [31:0]             session_tag_i,
  input  logic [31:0]             message_key_i,
  input  logic                    app_present_i,
  input  logic [31:0]             content_word_i,
  input  logic [63:0]             handle_key_i,
  input  logic                    read_value_i,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output logic [63:0]             new_handle_o,
  output logic                    hit_o,
  output logic                    hit_read_o,
  output logic [31:0]             hit_key_o,
  output logic [31:0]             hit_content_o
);

  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;

  // latched item
  logic [1:0]  act_q;
  logic [2:0]  kind_q;
  logic [31:0] sess_q, key_q, cont_q;
  logic        app_q, rdv_q, wipe_q;
  logic [63:0] hkey_q;

  logic [31:0] session_q;
  logic [63:0] ctr_q;
  logic [Depth-1:0] valid_q;

  logic [31:0] key_mem  [Depth];
  logic [63:0] hdl_mem  [Depth];
  logic        rd_mem   [Depth];
  logic [31:0] cont_mem [Depth];

  logic [IdxW-1:0] ptr_q, ridx_q;
  logic            rdv_stage_q;
  logic [31:0]     rk_q, rc_q;
  logic [63:0]     rh_q;
  logic            rr_q;

  // scan trackers
  logic            m_found_q, f_found_q, o_found_q, h_found_q;
  logic [IdxW-1:0] m_idx_q, f_idx_q, o_idx_q, h_idx_q;
  logic [63:0]     m_h_q, o_h_q;
  logic            h_read_q;
  logic [31:0]     h_key_q, h_cont_q;

  logic            out_valid_q;
  logic [63:0]     out_nh_q;
  logic            out_hit_q, out_hr_q;
  logic [31:0]     out_hk_q, out_hc_q;

  logic            ev;
  logic            is_apply, is_local, mt, kind_ins, ins, upd, rem, mark, erase, report;
  logic [IdxW-1:0] slot;
  logic            wipe_d;
  logic [Depth-1:0] valid_d;

  assign wipe_d = (kmtf_pkg::kind_e'(change_kind_i) != kmtf_pkg::KIND_LOCAL) &&
                  (action_i == kmtf_pkg::ACT_APPLY) &&
                  ((change_kind_i == kmtf_pkg::KIND_RESET) || (session_tag_i != session_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      act_q  <= action_i;
      kind_q <= change_kind_i;
      sess_q <= session_tag_i;
      key_q  <= message_key_i;
      app_q  <= app_present_i;
      cont_q <= content_word_i;
      hkey_q <= handle_key_i;
      rdv_q  <= read_value_i;
    end
  end

  // read port of the entry memories, one slot a cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan) begin
      rk_q   <= key_mem[ptr_q];
      rh_q   <= hdl_mem[ptr_q];
      rr_q   <= rd_mem[ptr_q];
      rc_q   <= cont_mem[ptr_q];
      ridx_q <= ptr_q;
    end
  end

  assign ev = valid_q[ridx_q] && !wipe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wipe_q      <= 1'b0;
      ptr_q       <= '0;
      rdv_stage_q <= 1'b0;
      m_found_q   <= 1'b0;
      f_found_q   <= 1'b0;
      o_found_q   <= 1'b0;
      h_found_q   <= 1'b0;
      m_idx_q     <= '0;
      f_idx_q     <= '0;
      o_idx_q     <= '0;
      h_idx_q     <= '0;
      m_h_q       <= '0;
      o_h_q       <= '0;
      h_read_q    <= 1'b0;
      h_key_q     <= '0;
      h_cont_q    <= '0;
    end else begin
      rdv_stage_q <= cmd_i.scan;
      if (cmd_i.start) begin
        wipe_q    <= wipe_d;
        ptr_q     <= '0;
        m_found_q <= 1'b0;
        f_found_q <= 1'b0;
        o_found_q <= 1'b0;
        h_found_q <= 1'b0;
      end else begin
        if (cmd_i.scan) ptr_q <= ptr_q + IdxW'(1);
        if (rdv_stage_q) begin
          if (ev && rk_q == key_q && (!m_found_q || rh_q < m_h_q)) begin
            m_found_q <= 1'b1;
            m_idx_q   <= ridx_q;
            m_h_q     <= rh_q;
          end
          if (!ev && !f_found_q) begin
            f_found_q <= 1'b1;
            f_idx_q   <= ridx_q;
          end
          if (ev && (!o_found_q || rh_q < o_h_q)) begin
            o_found_q <= 1'b1;
            o_idx_q   <= ridx_q;
            o_h_q     <= rh_q;
          end
          if (ev && rh_q == hkey_q && !h_found_q) begin
            h_found_q <= 1'b1;
            h_idx_q   <= ridx_q;
            h_read_q  <= rr_q;
            h_key_q   <= rk_q;
            h_cont_q  <= rc_q;
          end
        end
      end
    end
  end

  assign status_o.scan_last = (ptr_q == IdxW'(Depth - 1));
  assign status_o.out_busy  = out_valid_q && !out_ready_i;

  // commit decision
  assign is_apply = (act_q == kmtf_pkg::ACT_APPLY);
  assign is_local = (kind_q == kmtf_pkg::KIND_LOCAL);
  assign mt       = m_found_q && !is_local;
  assign kind_ins = (kind_q == kmtf_pkg::KIND_ADD) || (kind_q == kmtf_pkg::KIND_HIST) ||
                    is_local;
  assign report   = (kind_q == kmtf_pkg::KIND_ADD) || is_local;
  assign rem      = is_apply && (kind_q == kmtf_pkg::KIND_REMOVE) && mt;
  assign upd      = is_apply && (kind_q != kmtf_pkg::KIND_RESET) &&
                    (kind_q != kmtf_pkg::KIND_REMOVE) && app_q && mt;
  assign ins      = is_apply && app_q && !mt && kind_ins;
  assign mark     = (act_q == kmtf_pkg::ACT_MARK) && h_found_q;
  assign erase    = (act_q == kmtf_pkg::ACT_ERASE) && h_found_q;
  assign slot     = f_found_q ? f_idx_q : o_idx_q;

  always_comb begin
    valid_d = wipe_q ? '0 : valid_q;
    if (rem)   valid_d[m_idx_q] = 1'b0;
    if (ins)   valid_d[slot]    = 1'b1;
    if (erase) valid_d[h_idx_q] = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      session_q   <= '0;
      ctr_q       <= 64'd1;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        valid_q <= valid_d;
        if (wipe_q) session_q <= sess_q;
        if (ins)    ctr_q     <= ctr_q + 64'd1;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_nh_q  <= (ins && report) ? ctr_q : 64'd0;
      out_hit_q <= !is_apply && h_found_q;
      out_hr_q  <= (act_q == kmtf_pkg::ACT_FIND) && h_found_q && h_read_q;
      out_hk_q  <= ((act_q == kmtf_pkg::ACT_FIND) && h_found_q) ? h_key_q : 32'd0;
      out_hc_q  <= ((act_q == kmtf_pkg::ACT_FIND) && h_found_q) ? h_cont_q : 32'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && ins) begin
      key_mem[slot] <= key_q;
      hdl_mem[slot] <= ctr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && (ins || mark)) begin
      rd_mem[ins ? slot : h_idx_q] <= ins ? 1'b0 : rdv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && (ins || upd)) begin
      cont_mem[ins ? slot : m_idx_q] <= cont_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign new_handle_o  = out_nh_q;
  assign hit_o         = out_hit_q;
  assign hit_read_o    = out_hr_q;
  assign hit_key_o     = out_hk_q;
  assign hit_content_o = out_hc_q;

`ifndef SYNTHESIS
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> !(out_valid_q && !out_ready_i))
    else $error("commit while result register still held");
  a_ctr_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctr_q != $past(ctr_q)) |-> (ctr_q == $past(ctr_q) + 64'd1))
    else $error("handle counter moved by more than one");
  a_out_after_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.commit))
    else $error("result appeared without a commit");
`endif

endmodule

FILE: hw/rtl/keyed_message_table_fifo_evict_core.sv
// keyed message table with oldest-first eviction
// input stream s_axis_*: one transfer per request (apply change, find, mark read
// or erase by handle); output stream m_axis_*: exactly one result transfer per
// request, in order.
// each request is handled by a scan of the entry memories, one slot a cycle
// through a single registered read port, followed by a commit step; a new
// request is taken only once the previous one has been committed.
// the scan length is set by the single read port of the entry memories.
// results sit in an output register; the next request is accepted while a
// result waits, and only its commit waits for the receiver to take the
// previous result, so a stalled receiver stops the block at commit.
// reset clears all valid bits, sets the session to zero and the handle
// counter to one; no clearing pass is needed and requests are taken at once.
module keyed_message_table_fifo_evict_core #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // action, change_kind, session_tag, message_key, app_present, content_word,
  // handle_key, read_value
  input  logic [kmtf_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // new_handle, hit, hit_read, hit_key, hit_content
  output logic [kmtf_pkg::OutDataW-1:0]   m_axis_tdata
);

  kmtf_pkg::cmd_t    cmd;
  kmtf_pkg::status_t status;

  logic [63:0] new_handle;
  logic        hit, hit_read;
  logic [31:0] hit_key, hit_content;

  kmtf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  kmtf_dp #(
    .Depth (TABLE_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .action_i       (s_axis_tdata[1:0]),
    .change_kind_i  (s_axis_tdata[4:2]),
    .session_tag_i  (s_axis_tdata[36:5]),
    .message_key_i  (s_axis_tdata[68:37]),
    .app_present_i  (s_axis_tdata[69]),
    .content_word_i (s_axis_tdata[101:70]),
    .handle_key_i   (s_axis_tdata[165:102]),
    .read_value_i   (s_axis_tdata[166]),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .new_handle_o   (new_handle),
    .hit_o          (hit),
    .hit_read_o     (hit_read),
    .hit_key_o      (hit_key),
    .hit_content_o  (hit_content)
  );

  assign m_axis_tdata = {6'd0, hit_content, hit_key, hit_read, hit, new_handle};

endmodule
